[sv/escd_pkg.sv]
// ============================================================================
// escd_pkg
// Shared widths, reciprocal constants and pipeline control types for the
// epoch seconds to civil date converter.
// ============================================================================
`default_nettype none

package escd_pkg;

   // Pipeline depth: one register stage per entry
   localparam int NUM_STAGES = 8;

   // Field widths of intermediate values
   localparam int SECS_W = 32;
   localparam int DAY_W  = 16;   // days since 1970-01-01, up to 49710
   localparam int TOD_W  = 17;   // seconds within the day, below 86400
   localparam int MINS_W = 11;   // minutes within the day, below 1440
   localparam int WQ_W   = 13;   // weeks, below 7103
   localparam int DOE_W  = 18;   // day of the 400-year era
   localparam int YOE_W  = 9;    // year of the era, up to 399
   localparam int DOY_W  = 9;    // day of the March-based year, up to 365
   localparam int MP_W   = 4;    // March-based month, 0..11

   // Output field widths
   localparam int YEAR_W  = 8;
   localparam int MONTH_W = 4;
   localparam int MDAY_W  = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int WDAY_W  = 3;

   // Seconds per day and days at the first era boundary after the epoch
   localparam logic [TOD_W-1:0] SECS_PER_DAY     = 17'd86400;
   localparam logic [DAY_W-1:0] ERA_SPLIT_DAY    = 16'd11017;    // 2000-03-01
   localparam logic [DOE_W-1:0] DOE_BASE_ERA_LO  = 18'd135080;   // 719468 - 4 eras
   localparam logic [DOE_W-1:0] DOE_CENTURY_1    = 18'd36524;
   localparam logic [DOE_W-1:0] DOE_CENTURY_2    = 18'd73048;
   localparam logic [DOE_W-1:0] DOE_CENTURY_3    = 18'd109572;
   localparam logic [DOE_W-1:0] DOE_LAST_DAY     = 18'd146096;

   // Exact reciprocal multipliers: x / d == (x * MUL) >> SHIFT over the used range
   localparam logic [25:0] DIV675_MUL   = 26'd50903317;
   localparam int          DIV675_SHIFT = 35;
   localparam logic [16:0] DIV15_MUL    = 17'd69906;
   localparam int          DIV15_SHIFT  = 20;
   localparam logic [16:0] DIV7_MUL     = 17'd74899;
   localparam int          DIV7_SHIFT   = 19;
   localparam logic [15:0] DIV365_MUL   = 16'd45965;
   localparam int          DIV365_SHIFT = 24;
   localparam logic [9:0]  DIV100_MUL   = 10'd656;
   localparam int          DIV100_SHIFT = 16;
   localparam logic [12:0] DIV153_MUL   = 13'd6854;
   localparam int          DIV153_SHIFT = 20;

   // Per-stage load strobes from the flow control
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } stage_ctl_type;

   // First day of each March-based month within the year
   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
      logic [DOY_W-1:0] start;
      case (mp)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd184;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

`default_nettype wire

[sv/escd_flow.sv]
// ============================================================================
// escd_flow
// Valid bits and ready chain of the conversion pipeline; each stage loads
// when it is empty or the stage after it moves.
// ============================================================================
`default_nettype none

module escd_flow (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output escd_pkg::stage_ctl_type ctl
);
   import escd_pkg::*;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] rdy;
   logic [NUM_STAGES-1:0] shift_in;

   // Propagate ready backward: a stage can load when empty or draining
   always_comb begin
      rdy[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   // Advance valid bits into the stages that load
   assign shift_in = {vld_ff[NUM_STAGES-2:0], req_valid};
   assign vld_in   = (vld_ff & ~rdy) | (shift_in & rdy);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign ctl.load  = rdy;
   assign req_ready = rdy[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

endmodule

`default_nettype wire

[sv/escd_day_split.sv]
// ============================================================================
// escd_day_split
// Split epoch seconds into whole days and seconds within the day, using a
// reciprocal multiply for the division by 86400 (stages 0 and 1).
// ============================================================================
`default_nettype none

module escd_day_split (
   input  logic                          clock,
   input  escd_pkg::stage_ctl_type       ctl,
   input  logic [escd_pkg::SECS_W-1:0]   epoch_seconds,
   output logic [escd_pkg::DAY_W-1:0]    days,
   output logic [escd_pkg::TOD_W-1:0]    tod
);
   import escd_pkg::*;

   localparam int PROD_W = (SECS_W - 7) + 26;

   logic [PROD_W-1:0] day_prod;
   logic [DAY_W-1:0]  days0_in, days0_ff;
   logic [SECS_W-1:0] secs0_ff;
   logic [SECS_W-1:0] day_secs;
   logic [SECS_W-1:0] tod_full;
   logic [TOD_W-1:0]  tod1_in, tod1_ff;
   logic [DAY_W-1:0]  days1_ff;

   // Stage 0: days = (secs >> 7) / 675
   always_comb begin
      day_prod = PROD_W'(epoch_seconds[SECS_W-1:7]) * PROD_W'(DIV675_MUL);
      days0_in = day_prod[DIV675_SHIFT +: DAY_W];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         days0_ff <= days0_in;
         secs0_ff <= epoch_seconds;
      end
   end

   // Stage 1: remainder within the day
   always_comb begin
      day_secs = SECS_W'(days0_ff) * SECS_W'(SECS_PER_DAY);
      tod_full = secs0_ff - day_secs;
      tod1_in  = tod_full[TOD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         tod1_ff  <= tod1_in;
         days1_ff <= days0_ff;
      end
   end

   assign days = days1_ff;
   assign tod  = tod1_ff;

endmodule

`default_nettype wire

[sv/escd_clock_path.sv]
// ============================================================================
// escd_clock_path
// Hour, minute, second and weekday from the day split (stages 2 to 7).
// ============================================================================
`default_nettype none

module escd_clock_path (
   input  logic                          clock,
   input  escd_pkg::stage_ctl_type       ctl,
   input  logic [escd_pkg::DAY_W-1:0]    days,
   input  logic [escd_pkg::TOD_W-1:0]    tod,
   output logic [escd_pkg::HOUR_W-1:0]   hour_of_day,
   output logic [escd_pkg::MIN_W-1:0]    minute_of_hour,
   output logic [escd_pkg::SEC_W-1:0]    second_of_minute,
   output logic [escd_pkg::WDAY_W-1:0]   weekday
);
   import escd_pkg::*;

   localparam int MPROD_W = (TOD_W - 2) + 17;
   localparam int WPROD_W = DAY_W + 17;
   localparam int HPROD_W = (MINS_W - 2) + 17;

   // Stage 2
   logic [MPROD_W-1:0] mins_prod;
   logic [WPROD_W-1:0] wk_prod;
   logic [DAY_W-1:0]   wx2_in, wx2_ff;
   logic [MINS_W-1:0]  mins2_in, mins2_ff;
   logic [WQ_W-1:0]    wq2_in, wq2_ff;
   logic [TOD_W-1:0]   tod2_ff;
   // Stage 3
   logic [HPROD_W-1:0] hour_prod;
   logic [TOD_W-1:0]   sec_full;
   logic [DAY_W-1:0]   wday_full;
   logic [SEC_W-1:0]   sec3_in, sec3_ff;
   logic [HOUR_W-1:0]  hour3_in, hour3_ff;
   logic [WDAY_W-1:0]  wday3_in, wday3_ff;
   logic [MINS_W-1:0]  mins3_ff;
   // Stage 4
   logic [MINS_W-1:0]  min_full;
   logic [MIN_W-1:0]   min4_in, min4_ff;
   logic [SEC_W-1:0]   sec4_ff;
   logic [HOUR_W-1:0]  hour4_ff;
   logic [WDAY_W-1:0]  wday4_ff;
   // Stages 5 to 7: delay to line up with the date path
   logic [SEC_W-1:0]   sec5_ff, sec6_ff, sec7_ff;
   logic [HOUR_W-1:0]  hour5_ff, hour6_ff, hour7_ff;
   logic [MIN_W-1:0]   min5_ff, min6_ff, min7_ff;
   logic [WDAY_W-1:0]  wday5_ff, wday6_ff, wday7_ff;

   // Stage 2: minutes of day = (tod >> 2) / 15, weeks = (days + 4) / 7
   always_comb begin
      wx2_in    = days + DAY_W'(4);
      mins_prod = MPROD_W'(tod[TOD_W-1:2]) * MPROD_W'(DIV15_MUL);
      mins2_in  = mins_prod[DIV15_SHIFT +: MINS_W];
      wk_prod   = WPROD_W'(wx2_in) * WPROD_W'(DIV7_MUL);
      wq2_in    = wk_prod[DIV7_SHIFT +: WQ_W];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         wx2_ff   <= wx2_in;
         mins2_ff <= mins2_in;
         wq2_ff   <= wq2_in;
         tod2_ff  <= tod;
      end
   end

   // Stage 3: seconds, hour, weekday remainders
   always_comb begin
      sec_full  = tod2_ff - TOD_W'(TOD_W'(mins2_ff) * TOD_W'(60));
      sec3_in   = sec_full[SEC_W-1:0];
      hour_prod = HPROD_W'(mins2_ff[MINS_W-1:2]) * HPROD_W'(DIV15_MUL);
      hour3_in  = hour_prod[DIV15_SHIFT +: HOUR_W];
      wday_full = wx2_ff - DAY_W'(DAY_W'(wq2_ff) * DAY_W'(7));
      wday3_in  = wday_full[WDAY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         sec3_ff  <= sec3_in;
         hour3_ff <= hour3_in;
         wday3_ff <= wday3_in;
         mins3_ff <= mins2_ff;
      end
   end

   // Stage 4: minute within the hour
   always_comb begin
      min_full = mins3_ff - MINS_W'(MINS_W'(hour3_ff) * MINS_W'(60));
      min4_in  = min_full[MIN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         min4_ff  <= min4_in;
         sec4_ff  <= sec3_ff;
         hour4_ff <= hour3_ff;
         wday4_ff <= wday3_ff;
      end
   end

   // Stages 5 to 7: hold the time fields in step with the date fields
   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         sec5_ff  <= sec4_ff;
         hour5_ff <= hour4_ff;
         min5_ff  <= min4_ff;
         wday5_ff <= wday4_ff;
      end
      if (ctl.load[6]) begin
         sec6_ff  <= sec5_ff;
         hour6_ff <= hour5_ff;
         min6_ff  <= min5_ff;
         wday6_ff <= wday5_ff;
      end
      if (ctl.load[7]) begin
         sec7_ff  <= sec6_ff;
         hour7_ff <= hour6_ff;
         min7_ff  <= min6_ff;
         wday7_ff <= wday6_ff;
      end
   end

   assign hour_of_day      = hour7_ff;
   assign minute_of_hour   = min7_ff;
   assign second_of_minute = sec7_ff;
   assign weekday          = wday7_ff;

endmodule

`default_nettype wire

[sv/escd_date_path.sv]
// ============================================================================
// escd_date_path
// Gregorian date from the day count by era, day of era, year of era and
// March-based month (stages 2 to 7).
// ============================================================================
`default_nettype none

module escd_date_path (
   input  logic                          clock,
   input  escd_pkg::stage_ctl_type       ctl,
   input  logic [escd_pkg::DAY_W-1:0]    days,
   output logic [escd_pkg::YEAR_W-1:0]   years_since_1900,
   output logic [escd_pkg::MONTH_W-1:0]  month_index,
   output logic [escd_pkg::MDAY_W-1:0]   day_of_month
);
   import escd_pkg::*;

   localparam int CPROD_W = (DOE_W - 2) + 16;
   localparam int YPROD_W = DOE_W + 16;
   localparam int QPROD_W = YOE_W + 10;
   localparam int NUM_W   = 11;
   localparam int MPROD_W = NUM_W + 13;
   localparam int YSUM_W  = 10;

   // Stage 2
   logic               era2_in, era2_ff;
   logic [DOE_W-1:0]   doe2_in, doe2_ff;
   // Stage 3
   logic [CPROD_W-1:0] quad_prod;
   logic [6:0]         quads;
   logic [2:0]         cents;
   logic               last_day;
   logic [DOE_W-1:0]   num3_in, num3_ff;
   logic [DOE_W-1:0]   doe3_ff;
   logic               era3_ff;
   // Stage 4
   logic [YPROD_W-1:0] yoe_prod;
   logic [YOE_W-1:0]   yoe4_in, yoe4_ff;
   logic [DOE_W-1:0]   doe4_ff;
   logic               era4_ff;
   // Stage 5
   logic [QPROD_W-1:0] cent_prod;
   logic [DOE_W-1:0]   year_days;
   logic [DOE_W-1:0]   doy_full;
   logic [DOY_W-1:0]   doy5_in, doy5_ff;
   logic [YOE_W-1:0]   yoe5_ff;
   logic               era5_ff;
   // Stage 6
   logic [NUM_W-1:0]   mp_num;
   logic [MPROD_W-1:0] mp_prod;
   logic [MP_W-1:0]    mp6_in, mp6_ff;
   logic [DOY_W-1:0]   doy6_ff;
   logic [YOE_W-1:0]   yoe6_ff;
   logic               era6_ff;
   // Stage 7
   logic               early_month;
   logic [DOY_W-1:0]   mday_full;
   logic [YSUM_W-1:0]  year_sum;
   logic [YEAR_W-1:0]  year7_in, year7_ff;
   logic [MONTH_W-1:0] month7_in, month7_ff;
   logic [MDAY_W-1:0]  mday7_in, mday7_ff;

   // Stage 2: pick the era (1600 or 2000) and take the day of era
   always_comb begin
      era2_in = (days >= ERA_SPLIT_DAY);
      if (era2_in) begin
         doe2_in = DOE_W'(days) - DOE_W'(ERA_SPLIT_DAY);
      end else begin
         doe2_in = DOE_W'(days) + DOE_BASE_ERA_LO;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         era2_ff <= era2_in;
         doe2_ff <= doe2_in;
      end
   end

   // Stage 3: leap day corrections of the day of era
   always_comb begin
      quad_prod = CPROD_W'(doe2_ff[DOE_W-1:2]) * CPROD_W'(DIV365_MUL);
      quads     = quad_prod[DIV365_SHIFT +: 7];
      cents     = 3'(doe2_ff >= DOE_CENTURY_1) + 3'(doe2_ff >= DOE_CENTURY_2)
                + 3'(doe2_ff >= DOE_CENTURY_3) + 3'(doe2_ff >= DOE_LAST_DAY);
      last_day  = (doe2_ff == DOE_LAST_DAY);
      num3_in   = doe2_ff - DOE_W'(quads) + DOE_W'(cents) - DOE_W'(last_day);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         num3_ff <= num3_in;
         doe3_ff <= doe2_ff;
         era3_ff <= era2_ff;
      end
   end

   // Stage 4: year of era = corrected days / 365
   always_comb begin
      yoe_prod = YPROD_W'(num3_ff) * YPROD_W'(DIV365_MUL);
      yoe4_in  = yoe_prod[DIV365_SHIFT +: YOE_W];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         yoe4_ff <= yoe4_in;
         doe4_ff <= doe3_ff;
         era4_ff <= era3_ff;
      end
   end

   // Stage 5: day of the March-based year
   always_comb begin
      cent_prod = QPROD_W'(yoe4_ff) * QPROD_W'(DIV100_MUL);
      year_days = DOE_W'(DOE_W'(yoe4_ff) * DOE_W'(365))
                + DOE_W'(yoe4_ff[YOE_W-1:2])
                - DOE_W'(cent_prod[DIV100_SHIFT +: 2]);
      doy_full  = doe4_ff - year_days;
      doy5_in   = doy_full[DOY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         doy5_ff <= doy5_in;
         yoe5_ff <= yoe4_ff;
         era5_ff <= era4_ff;
      end
   end

   // Stage 6: March-based month = (5 * doy + 2) / 153
   always_comb begin
      mp_num  = NUM_W'(NUM_W'(doy5_ff) * NUM_W'(5)) + NUM_W'(2);
      mp_prod = MPROD_W'(mp_num) * MPROD_W'(DIV153_MUL);
      mp6_in  = mp_prod[DIV153_SHIFT +: MP_W];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[6]) begin
         mp6_ff  <= mp6_in;
         doy6_ff <= doy5_ff;
         yoe6_ff <= yoe5_ff;
         era6_ff <= era5_ff;
      end
   end

   // Stage 7: day of month, January-based month, year offset from 1900
   always_comb begin
      early_month = (mp6_ff >= MP_W'(10));
      mday_full   = doy6_ff - month_start(mp6_ff) + DOY_W'(1);
      mday7_in    = mday_full[MDAY_W-1:0];
      if (early_month) begin
         month7_in = mp6_ff - MP_W'(10);
      end else begin
         month7_in = mp6_ff + MP_W'(2);
      end
      // 2000 era adds 100, 1600 era subtracts 300 (mod 1024)
      year_sum = YSUM_W'(yoe6_ff) + (era6_ff ? YSUM_W'(100) : YSUM_W'(724))
               + YSUM_W'(early_month);
      year7_in = year_sum[YEAR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[7]) begin
         year7_ff  <= year7_in;
         month7_ff <= month7_in;
         mday7_ff  <= mday7_in;
      end
   end

   assign years_since_1900 = year7_ff;
   assign month_index      = month7_ff;
   assign day_of_month     = mday7_ff;

endmodule

`default_nettype wire

[sv/epoch_seconds_to_civil_date.sv]
// ============================================================================
// epoch_seconds_to_civil_date
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC
// into year since 1900, month, day of month, hour, minute, second and
// weekday. The block is an eight-stage pipeline. An item enters stage 0 at
// the edge that accepts it, and its result is offered from stage 7. A new
// item is taken every cycle unless a stalled output has filled every
// stage. The depth comes from the reciprocal multiplies (days, minutes,
// hours, year of era, month) and the subtractions that follow them, with
// one step per register. Each stage holds its item when the next one is
// full and stalled. Bubbles close up, so the input keeps accepting while a
// finished result waits at the output, until every stage is full. Leap
// seconds are not modeled; there is no configuration and no other state.
// ============================================================================
`default_nettype none

module epoch_seconds_to_civil_date (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [escd_pkg::SECS_W-1:0]    req_epoch_seconds,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [escd_pkg::YEAR_W-1:0]    rsp_years_since_1900,
   output logic [escd_pkg::MONTH_W-1:0]   rsp_month_index,
   output logic [escd_pkg::MDAY_W-1:0]    rsp_day_of_month,
   output logic [escd_pkg::HOUR_W-1:0]    rsp_hour_of_day,
   output logic [escd_pkg::MIN_W-1:0]     rsp_minute_of_hour,
   output logic [escd_pkg::SEC_W-1:0]     rsp_second_of_minute,
   output logic [escd_pkg::WDAY_W-1:0]    rsp_weekday
);
   import escd_pkg::*;

   stage_ctl_type    ctl;
   logic [DAY_W-1:0] days;
   logic [TOD_W-1:0] tod;

   // Valid bits and stage load strobes
   escd_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   // Days and seconds of day
   escd_day_split u_day_split (
      .clock         (clock),
      .ctl           (ctl),
      .epoch_seconds (req_epoch_seconds),
      .days          (days),
      .tod           (tod)
   );

   // Time of day and weekday
   escd_clock_path u_clock_path (
      .clock            (clock),
      .ctl              (ctl),
      .days             (days),
      .tod              (tod),
      .hour_of_day      (rsp_hour_of_day),
      .minute_of_hour   (rsp_minute_of_hour),
      .second_of_minute (rsp_second_of_minute),
      .weekday          (rsp_weekday)
   );

   // Calendar date
   escd_date_path u_date_path (
      .clock            (clock),
      .ctl              (ctl),
      .days             (days),
      .years_since_1900 (rsp_years_since_1900),
      .month_index      (rsp_month_index),
      .day_of_month     (rsp_day_of_month)
   );

endmodule

`default_nettype wire

[sv/escd_checker.sv]
// ============================================================================
// escd_checker
// Port-level checks of the converter: reset, stall hold and field ranges of
// every result item.
// ============================================================================
`default_nettype none

module escd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [escd_pkg::YEAR_W-1:0]    rsp_years_since_1900,
   input logic [escd_pkg::MONTH_W-1:0]   rsp_month_index,
   input logic [escd_pkg::MDAY_W-1:0]    rsp_day_of_month,
   input logic [escd_pkg::HOUR_W-1:0]    rsp_hour_of_day,
   input logic [escd_pkg::MIN_W-1:0]     rsp_minute_of_hour,
   input logic [escd_pkg::SEC_W-1:0]     rsp_second_of_minute,
   input logic [escd_pkg::WDAY_W-1:0]    rsp_weekday
);

   // Pipeline empties on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result item holds its fields
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_years_since_1900)
         && $stable(rsp_month_index) && $stable(rsp_day_of_month)
         && $stable(rsp_hour_of_day) && $stable(rsp_minute_of_hour)
         && $stable(rsp_second_of_minute) && $stable(rsp_weekday))
      else $error("stalled result changed");

   // Date fields stay in calendar range
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_years_since_1900 >= 8'd70 && rsp_years_since_1900 <= 8'd206
         && rsp_month_index <= 4'd11 && rsp_day_of_month >= 5'd1)
      else $error("date field out of range");

   // Time fields stay in clock range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hour_of_day <= 5'd23 && rsp_minute_of_hour <= 6'd59
         && rsp_second_of_minute <= 6'd59 && rsp_weekday <= 3'd6)
      else $error("time field out of range");

   // February cannot show day 30 or 31
   a_feb_days: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_month_index == 4'd1 |-> rsp_day_of_month <= 5'd29)
      else $error("February day out of range");

endmodule

bind epoch_seconds_to_civil_date escd_checker u_escd_checker (.*);

`default_nettype wire

[tb/civil_date_check_pkg.sv]
// ============================================================================
// civil_date_check_pkg
// Expected-date store for the epoch seconds to civil date converter. Each
// accepted timestamp is turned into its calendar date and time of day and
// queued; each result from the block is compared with the oldest entry.
// ============================================================================
`default_nettype none

package civil_date_check_pkg;

   import escd_pkg::*;

   localparam int unsigned DAY_SECONDS        = 86400;
   localparam int unsigned HOUR_SECONDS       = 3600;
   localparam int unsigned MINUTE_SECONDS     = 60;
   localparam int unsigned MARCH0_OFFSET_DAYS = 719468;   // 1970-01-01 counted from 0000-03-01
   localparam int unsigned ERA_DAYS           = 146097;   // days in 400 Gregorian years
   localparam int unsigned EPOCH_WEEKDAY      = 4;        // 1970-01-01 was a Thursday

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [MDAY_W-1:0]  mday;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   second;
      logic [WDAY_W-1:0]  wday;
   } civil_date_type;

   class civil_date_ledger;

      civil_date_type pending_dates[$];
      int unsigned    mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Convert seconds since the epoch to a broken-down Gregorian date
      static function civil_date_type seconds_to_civil(input logic [SECS_W-1:0] secs);
         int unsigned days, tod, shifted, era, doe, yoe, year, doy, mp, mday, mon;
         civil_date_type d;
         days = secs / DAY_SECONDS;
         tod  = secs % DAY_SECONDS;

         // Count days from 0000-03-01 and split into eras of 400 years
         shifted = days + MARCH0_OFFSET_DAYS;
         era     = shifted / ERA_DAYS;
         doe     = shifted - era * ERA_DAYS;
         yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
         year    = yoe + era * 400;
         doy     = doe - (365 * yoe + yoe / 4 - yoe / 100);
         mp      = (5 * doy + 2) / 153;
         mday    = doy - (153 * mp + 2) / 5 + 1;
         mon     = (mp < 10) ? mp + 3 : mp - 9;

         // January and February belong to the next civil year
         if (mon <= 2) begin
            year = year + 1;
         end

         d.year   = YEAR_W'(year - 1900);
         d.month  = MONTH_W'(mon - 1);
         d.mday   = MDAY_W'(mday);
         d.hour   = HOUR_W'(tod / HOUR_SECONDS);
         d.minute = MIN_W'((tod % HOUR_SECONDS) / MINUTE_SECONDS);
         d.second = SEC_W'(tod % MINUTE_SECONDS);
         d.wday   = WDAY_W'((days + EPOCH_WEEKDAY) % 7);
         return d;
      endfunction

      function void note_timestamp(input logic [SECS_W-1:0] secs);
         pending_dates.push_back(seconds_to_civil(secs));
      endfunction

      function void compare_field(input string name, input int unsigned want,
                                  input int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      // Compare one result against the oldest expected date
      function void check_date(input civil_date_type got);
         civil_date_type want;
         if (pending_dates.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                     $time, got.year, got.month, got.mday, got.hour, got.minute, got.second);
            mismatches++;
            return;
         end
         want = pending_dates.pop_front();
         compare_field("years_since_1900", want.year,   got.year);
         compare_field("month_index",      want.month,  got.month);
         compare_field("day_of_month",     want.mday,   got.mday);
         compare_field("hour_of_day",      want.hour,   got.hour);
         compare_field("minute_of_hour",   want.minute, got.minute);
         compare_field("second_of_minute", want.second, got.second);
         compare_field("weekday",          want.wday,   got.wday);
      endfunction

   endclass

endpackage

`default_nettype wire

[tb/tb.sv]
// ============================================================================
// tb
// Testbench for epoch_seconds_to_civil_date. Drives calendar landmarks, then
// random timestamps with random gaps and stalls on both channels, and checks
// every result against an independent date conversion.
// ============================================================================
`default_nettype none

module tb;

   timeunit 1ns;
   timeprecision 1ps;

   import escd_pkg::*;
   import civil_date_check_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1832;
   localparam int unsigned STALL_LIMIT  = 5000;
   localparam int unsigned HOLD_CYCLES  = 150;
   localparam int unsigned NUM_PHASES   = 4;

   // Leap days, century rules, era edge, 2038 rollover and the top of the range
   localparam logic [SECS_W-1:0] LANDMARKS [20] = '{
      32'd0,          32'd86399,      32'd86400,      32'd68169599,
      32'd68169600,   32'd68255999,   32'd68256000,   32'd946684799,
      32'd946684800,  32'd951782400,  32'd951868799,  32'd951868800,
      32'd2147483647, 32'd2147483648, 32'd4107542399, 32'd4107542400,
      32'd4294944000, 32'd4294967295, 32'hAAAAAAAA,   32'h55555555
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SECS_W-1:0]   req_epoch_seconds = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [YEAR_W-1:0]   rsp_years_since_1900;
   logic [MONTH_W-1:0]  rsp_month_index;
   logic [MDAY_W-1:0]   rsp_day_of_month;
   logic [HOUR_W-1:0]   rsp_hour_of_day;
   logic [MIN_W-1:0]    rsp_minute_of_hour;
   logic [SEC_W-1:0]    rsp_second_of_minute;
   logic [WDAY_W-1:0]   rsp_weekday;

   civil_date_ledger    ledger;
   bit                  send_gaps_on = 1'b0;
   bit                  recv_gaps_on = 1'b0;
   bit                  hold_request = 1'b0;
   int unsigned         quiet_cycles = 0;

   epoch_seconds_to_civil_date dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_years_since_1900 (rsp_years_since_1900),
      .rsp_month_index      (rsp_month_index),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_weekday          (rsp_weekday)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one
   function automatic int unsigned gap_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Random timestamp: raw bits, near midnight or the hour, or near the top
   function automatic logic [SECS_W-1:0] pick_timestamp();
      longint unsigned stamp;
      case ($urandom_range(0, 3))
         0: stamp = $urandom;
         1: stamp = longint'($urandom_range(0, 49710)) * DAY_SECONDS
                    + ($urandom_range(0, 1) ? $urandom_range(0, 2) : 86397 + $urandom_range(0, 2));
         2: stamp = longint'($urandom_range(0, 49710)) * DAY_SECONDS
                    + $urandom_range(0, 23) * HOUR_SECONDS
                    + ($urandom_range(0, 1) ? 3599 : $urandom_range(0, 3599));
         default: stamp = 64'hFFFF_FFFF - $urandom_range(0, 200000000);
      endcase
      if (stamp > 64'hFFFF_FFFF) begin
         stamp = 64'hFFFF_FFFF;
      end
      return stamp[SECS_W-1:0];
   endfunction

   // Offer one timestamp, hold it until accepted, then idle for a random gap when gaps are on
   task automatic send_timestamp(input logic [SECS_W-1:0] secs);
      int unsigned gap;
      req_epoch_seconds <= secs;
      req_valid         <= 1'b1;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      gap = send_gaps_on ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every expected date has come back
   task automatic drain_dates();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending_dates.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Result side: long hold on request, otherwise bursts of ready and stalls
   initial begin : receiver
      int unsigned stall;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!recv_gaps_on) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            stall = gap_length();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   // Record accepted timestamps, check results, watch for a hang
   always @(posedge clock) begin : monitor
      bit             moved;
      civil_date_type got;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && req_ready) begin
            ledger.note_timestamp(req_epoch_seconds);
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_years_since_1900, rsp_month_index, rsp_day_of_month,
                    rsp_hour_of_day, rsp_minute_of_hour, rsp_second_of_minute,
                    rsp_weekday};
            ledger.check_date(got);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      ledger = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Landmarks, back to back, then let the pipeline empty
      foreach (LANDMARKS[i]) begin
         send_timestamp(LANDMARKS[i]);
      end
      drain_dates();

      // Random timestamps under different idle profiles
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               send_gaps_on = 1'b1;
               recv_gaps_on = 1'b1;
            end
            1: begin
               send_gaps_on = 1'b0;
               recv_gaps_on = 1'b1;
               hold_request = 1'b1;
            end
            2: begin
               send_gaps_on = 1'b1;
               recv_gaps_on = 1'b0;
            end
            default: begin
               send_gaps_on = 1'b0;
               recv_gaps_on = 1'b0;
            end
         endcase
         repeat (RANDOM_ITEMS / NUM_PHASES) send_timestamp(pick_timestamp());
         if (phase == 1) begin
            drain_dates();
         end
      end

      // Wait out the last results and any stray ones
      drain_dates();
      repeat (NUM_STAGES * 4) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending_dates.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
